### src/can_frame_packet_reassembler_defines.svh
// Assertion macros used by the reassembler back end (cfpr_back).
`ifndef CAN_FRAME_PACKET_REASSEMBLER_DEFINES_SVH
`define CAN_FRAME_PACKET_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CFPR_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define CFPR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### src/cfpr_pkg.sv
`timescale 1ns / 1ps

package cfpr_pkg;

  localparam int NUM_DATA = 7;

  localparam logic [7:0] MARK_START = 8'h0A;
  localparam logic [7:0] MARK_CONT  = 8'h0D;
  localparam logic [3:0] LEN_MAX    = 4'h8;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] dlc_t;
  typedef logic [2:0] nbytes_t;
  typedef logic [5:0] idx_t;
  typedef logic [8:0] count_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_START,
    KIND_CONT
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    nbytes_t                 n;
    byte_t                   type_byte;
    byte_t [NUM_DATA-1:0]    data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAIN,
    ST_APPEND,
    ST_CHECK,
    ST_EMPTY,
    ST_EMIT
  } state_t;

endpackage

### src/cfpr_if.sv
`timescale 1ns / 1ps

interface cfpr_in_if import cfpr_pkg::*; ();
  logic  valid;
  logic  ready;
  dlc_t  frame_length;
  byte_t type_byte;
  byte_t data_0;
  byte_t data_1;
  byte_t data_2;
  byte_t data_3;
  byte_t data_4;
  byte_t data_5;
  byte_t data_6;

  modport source (
    output valid, frame_length, type_byte,
    output data_0, data_1, data_2, data_3, data_4, data_5, data_6,
    input  ready
  );

  modport sink (
    input  valid, frame_length, type_byte,
    input  data_0, data_1, data_2, data_3, data_4, data_5, data_6,
    output ready
  );
endinterface

interface cfpr_out_if import cfpr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t packet_type;
  byte_t packet_size;
  idx_t  byte_index;
  byte_t packet_byte;
  logic  has_data;
  logic  overflow;
  logic  last;

  modport source (
    output valid, packet_type, packet_size, byte_index, packet_byte,
    output has_data, overflow, last,
    input  ready
  );

  modport sink (
    input  valid, packet_type, packet_size, byte_index, packet_byte,
    input  has_data, overflow, last,
    output ready
  );
endinterface

### src/cfpr_front.sv
`timescale 1ns / 1ps

module cfpr_front import cfpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  cfpr_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic    enable_r;
  logic    enable_nxt;
  nbytes_t n;
  kind_t   kind;

  always_comb begin
    enable_nxt = cfg_we ? cfg_wdata : enable_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  // Frames that arrive while disabled are taken and dropped.
  assign in_ch.ready = !enable_r || !q_full;
  assign q_push      = in_ch.valid && enable_r && !q_full;

  always_comb begin
    if (in_ch.frame_length == '0) begin
      n = '0;
    end else if (in_ch.frame_length > LEN_MAX) begin
      n = nbytes_t'(NUM_DATA);
    end else begin
      n = nbytes_t'(in_ch.frame_length - 4'd1);
    end
  end

  always_comb begin
    case (in_ch.type_byte)
      MARK_START: kind = KIND_START;
      MARK_CONT:  kind = KIND_CONT;
      default:    kind = KIND_PLAIN;
    endcase
  end

  always_comb begin
    q_cmd.kind      = kind;
    q_cmd.n         = n;
    q_cmd.type_byte = in_ch.type_byte;
    q_cmd.data[0]   = in_ch.data_0;
    q_cmd.data[1]   = in_ch.data_1;
    q_cmd.data[2]   = in_ch.data_2;
    q_cmd.data[3]   = in_ch.data_3;
    q_cmd.data[4]   = in_ch.data_4;
    q_cmd.data[5]   = in_ch.data_5;
    q_cmd.data[6]   = in_ch.data_6;
  end

endmodule

### src/cfpr_queue.sv
`timescale 1ns / 1ps

module cfpr_queue import cfpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/cfpr_back.sv
`timescale 1ns / 1ps
`include "can_frame_packet_reassembler_defines.svh"

module cfpr_back import cfpr_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  cfpr_out_if.source out_ch
);

  localparam int AW = $clog2(BUF_DEPTH);

  state_t  state_r;
  state_t  state_nxt;
  cmd_t    cur_r;
  cmd_t    cur_nxt;
  nbytes_t i_r;
  nbytes_t i_nxt;
  count_t  count_r;
  count_t  count_nxt;
  count_t  count_eff;
  byte_t   atype_r;
  byte_t   atype_nxt;
  byte_t   asize_r;
  byte_t   asize_nxt;
  idx_t    k_r;
  idx_t    k_nxt;
  byte_t   k_inc;
  byte_t   emit_r;
  byte_t   emit_nxt;
  logic    ovf_r;
  logic    ovf_nxt;

  byte_t   buf_mem [BUF_DEPTH];
  byte_t   rd_data_r;
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  byte_t   mem_wdata;
  logic    rd_en;
  logic [AW-1:0] rd_addr;

  logic    out_valid_r;
  logic    out_valid_nxt;
  byte_t   out_type_r;
  byte_t   out_size_r;
  idx_t    out_idx_r;
  byte_t   out_byte_r;
  logic    out_has_r;
  logic    out_ovf_r;
  logic    out_last_r;
  logic    load;
  byte_t   ld_type;
  byte_t   ld_size;
  idx_t    ld_idx;
  byte_t   ld_byte;
  logic    ld_has;
  logic    ld_ovf;
  logic    ld_last;

  logic    slot_free;
  logic    plain_last;
  logic    emit_last;
  logic    append_more;
  logic    complete;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign k_inc       = {2'b00, k_r} + 8'd1;
  assign plain_last  = (cur_r.n == '0) || (k_inc == {5'b00000, cur_r.n});
  assign emit_last   = (k_inc == emit_r);
  assign append_more = (i_r < cur_r.n);
  assign complete    = (count_r >= {1'b0, asize_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_cmd.kind == KIND_PLAIN) ? ST_PLAIN : ST_APPEND;
        end
      end
      ST_PLAIN: begin
        if (slot_free && plain_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_APPEND: begin
        if (!append_more) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!complete) begin
          state_nxt = ST_IDLE;
        end else if (asize_r == '0) begin
          state_nxt = ST_EMPTY;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    cur_nxt   = cur_r;
    i_nxt     = i_r;
    count_nxt = count_r;
    count_eff = count_r;
    atype_nxt = atype_r;
    asize_nxt = asize_r;
    k_nxt     = k_r;
    emit_nxt  = emit_r;
    ovf_nxt   = ovf_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = cur_r.data[i_r];
    rd_en     = 1'b0;
    rd_addr   = k_inc[AW-1:0];
    load      = 1'b0;
    ld_type   = atype_r;
    ld_size   = asize_r;
    ld_idx    = k_r;
    ld_byte   = rd_data_r;
    ld_has    = 1'b1;
    ld_ovf    = ovf_r;
    ld_last   = emit_last;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          k_nxt   = '0;
          i_nxt   = '0;
          if (q_cmd.kind != KIND_PLAIN) begin
            count_eff = (q_cmd.kind == KIND_START) ? '0 : count_r;
            count_nxt = count_eff;
            if ((count_eff == '0) && (q_cmd.n > 3'd2)) begin
              atype_nxt = q_cmd.data[0];
              asize_nxt = q_cmd.data[1];
              i_nxt     = 3'd2;
            end
          end
        end
      end
      ST_PLAIN: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_type = cur_r.type_byte;
          ld_size = {5'b00000, cur_r.n};
          ld_byte = (cur_r.n == '0) ? '0 : cur_r.data[k_r[2:0]];
          ld_has  = (cur_r.n != '0);
          ld_ovf  = 1'b0;
          ld_last = plain_last;
          k_nxt   = k_r + 6'd1;
        end
      end
      ST_APPEND: begin
        if (append_more) begin
          // Bytes past the buffer still advance the count.
          mem_we    = (count_r < count_t'(BUF_DEPTH));
          count_nxt = count_r + 9'd1;
          i_nxt     = i_r + 3'd1;
        end
      end
      ST_CHECK: begin
        if (complete) begin
          count_nxt = '0;
          ovf_nxt   = (asize_r > byte_t'(BUF_DEPTH));
          emit_nxt  = (asize_r > byte_t'(BUF_DEPTH)) ? byte_t'(BUF_DEPTH) : asize_r;
          k_nxt     = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_size = '0;
          ld_idx  = '0;
          ld_byte = '0;
          ld_has  = 1'b0;
          ld_ovf  = 1'b0;
          ld_last = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          // The next byte is fetched as this one leaves the read register.
          load  = 1'b1;
          k_nxt = k_r + 6'd1;
          rd_en = !emit_last;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      atype_r     <= '0;
      asize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      atype_r     <= atype_nxt;
      asize_r     <= asize_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    emit_r <= emit_nxt;
    ovf_r  <= ovf_nxt;
    if (load) begin
      out_type_r <= ld_type;
      out_size_r <= ld_size;
      out_idx_r  <= ld_idx;
      out_byte_r <= ld_byte;
      out_has_r  <= ld_has;
      out_ovf_r  <= ld_ovf;
      out_last_r <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= buf_mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packet_type = out_type_r;
  assign out_ch.packet_size = out_size_r;
  assign out_ch.byte_index  = out_idx_r;
  assign out_ch.packet_byte = out_byte_r;
  assign out_ch.has_data    = out_has_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.last        = out_last_r;

  `CFPR_ASSERT_IMPLY(a_empty_item_alone, clk, rst_n, (out_valid_r && !out_has_r), (out_last_r && (out_idx_r == '0)))
  `CFPR_ASSERT_IMPLY(a_overflow_size, clk, rst_n, (out_valid_r && out_ovf_r), (out_size_r > byte_t'(BUF_DEPTH)))
  `CFPR_ASSERT_NEXT(a_count_cleared, clk, rst_n, ((state_r == ST_CHECK) && complete), (count_r == '0))
  `CFPR_ASSERT_IMPLY(a_emit_in_range, clk, rst_n, (state_r == ST_EMIT), ((k_inc <= emit_r) && (emit_r <= byte_t'(BUF_DEPTH))))

endmodule

### src/can_frame_packet_reassembler.sv
`timescale 1ns / 1ps

// Reassembles segmented packets from received CAN frames.
// in_ch takes one frame per item: length code, type byte and seven data bytes.
// out_ch gives one item per packet byte, with type, declared size, index,
// an overflow flag and last; an empty packet gives one item with has_data low.
// cfg_we writes cfg_wdata into the enable bit; while it is low, frames are
// taken and dropped.
// A two-entry queue lets frames be taken while a packet is still being sent.
// An ordinary frame passes through the queue, the current-frame register and
// the output register before its first item is valid; its n bytes then leave
// at one item per cycle while the receiver is ready.
// A segment frame's data bytes, past the type and size of a header frame, are
// written to the buffer memory one per cycle.
// A completed packet leaves at one item per cycle while the receiver is ready,
// up to BUF_DEPTH items, paced by the single read port of the buffer memory.
// When the receiver stalls, the output register holds its item and the
// queue fills; if enabled, in_ch.ready falls once the queue holds two frames.
// Reset clears the queue, the assembly count, type and size and sets the
// enable bit; the buffer needs no clearing.
module can_frame_packet_reassembler import cfpr_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  cfpr_in_if.sink    in_ch,
  cfpr_out_if.source out_ch
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  cfpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  cfpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  cfpr_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cmd   (pop_cmd),
    .out_ch  (out_ch)
  );

endmodule
